/* rtl/tmc_pkg.sv */
`timescale 1ns / 1ps

package tmc_pkg;

  // command codes carried in s_axis_tuser
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_BUTTON = 2'd1;
  localparam logic [1:0] CMD_ROTARY = 2'd2;
  localparam logic [1:0] CMD_SAMPLE = 2'd3;

  // menu state codes
  localparam logic [1:0] MENU_LOW    = 2'd0;
  localparam logic [1:0] MENU_HIGH   = 2'd1;
  localparam logic [1:0] MENU_NORMAL = 2'd2;

  // register map, index taken from paddr[2]
  localparam logic REG_IDLE_TIMEOUT   = 1'b0;
  localparam logic REG_DISPLAY_OFFSET = 1'b1;
  localparam int unsigned AddrWidth   = 3;

  // reset values
  localparam logic [15:0] IdleTimeoutReset   = 16'd4000;
  localparam logic [6:0]  DisplayOffsetReset = 7'd20;
  localparam logic [7:0]  LowLevelReset      = 8'd24;
  localparam logic [7:0]  HighLevelReset     = 8'd25;

  // display symbols
  localparam logic [3:0] SYM_MINUS     = 4'd0;
  localparam logic [3:0] SYM_PLUS      = 4'd11;
  localparam logic [6:0] NORMAL_LIGHTS = 7'h7E;

  localparam int unsigned InDataWidth  = 16;
  localparam int unsigned OutDataWidth = 32;

  // seven segment patterns: minus, digits 0..9, plus
  function automatic logic [6:0] seg_pattern(input logic [3:0] sym);
    logic [6:0] pat;
    case (sym)
      4'd0:    pat = 7'h08;
      4'd1:    pat = 7'h7E;
      4'd2:    pat = 7'h30;
      4'd3:    pat = 7'h6D;
      4'd4:    pat = 7'h79;
      4'd5:    pat = 7'h33;
      4'd6:    pat = 7'h5B;
      4'd7:    pat = 7'h5F;
      4'd8:    pat = 7'h70;
      4'd9:    pat = 7'h7F;
      4'd10:   pat = 7'h7B;
      4'd11:   pat = 7'h40;
      default: pat = 7'h00;
    endcase
    return pat;
  endfunction

endpackage

/* rtl/thermostat_menu_controller_top.sv */
`timescale 1ns / 1ps

// thermostat with setup menu
// slave stream: one event per request, kind in s_axis_tuser (tick, button,
//   rotary step, temperature sample), direction and sample in s_axis_tdata
// master stream: one result per event with relay, menu state, display
//   pattern and both thresholds, as they stand after the event
// apb port: idle timeout at 0x0, display offset at 0x4; the user keeps
//   writes only while no event is in flight, the block does not enforce it
// path: an accepted request goes into the input register, then into the state
//   registers, which also hold the result
// throughput: one event per clock cycle while the receiver takes each result,
//   set by the update of the state registers
// receiver stall: the pending result holds, one more event waits in the
//   input register, then s_axis_tready falls until the result is taken
// reset: menu in low setup, thresholds 24 and 25, relay off, display dark,
//   idle counter zero, timeout 4000, display offset 20
module thermostat_menu_controller_top
  import tmc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // slave stream
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [InDataWidth-1:0]  s_axis_tdata,  // step_up, temperature, zero pad
  input  logic [1:0]              s_axis_tuser,  // command
  // master stream
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // relay_on, menu_state, segments, low_level, high_level, zero pad
  output logic [OutDataWidth-1:0] m_axis_tdata,
  // configuration
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [AddrWidth-1:0]    paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  // configuration registers
  logic [15:0] idle_timeout_q;
  logic [6:0]  display_offset_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_timeout_q   <= IdleTimeoutReset;
      display_offset_q <= DisplayOffsetReset;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_IDLE_TIMEOUT) begin
        idle_timeout_q <= pwdata[15:0];
      end else begin
        display_offset_q <= pwdata[6:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_IDLE_TIMEOUT) begin
      prdata = {16'd0, idle_timeout_q};
    end else begin
      prdata = {25'd0, display_offset_q};
    end
  end

  // flow control
  logic       in_valid_q;
  logic [1:0] cmd_q;
  logic       step_up_q;
  logic [7:0] temp_q;
  logic       out_valid_q;
  logic       advance;
  logic       proc;

  assign advance       = !out_valid_q || m_axis_tready;
  assign proc          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      cmd_q     <= s_axis_tuser;
      step_up_q <= s_axis_tdata[0];
      temp_q    <= s_axis_tdata[8:1];
    end
  end

  // state registers, which also form the result register
  logic [1:0]  menu_q, menu_d;
  logic [15:0] idle_q, idle_d;
  logic [7:0]  low_q, low_d;
  logic [7:0]  high_q, high_d;
  logic        relay_q, relay_d;
  logic [6:0]  seg_q, seg_d;

  logic        setup;
  logic [15:0] idle_inc;
  logic [7:0]  level_cur;
  logic [7:0]  level_new;
  logic [9:0]  temp_ext;
  logic [8:0]  sym_idx;
  logic [3:0]  sym;

  assign setup     = (menu_q != MENU_NORMAL);
  assign idle_inc  = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;
  assign level_cur = (menu_q == MENU_HIGH) ? high_q : low_q;
  assign temp_ext  = {{2{temp_q[7]}}, temp_q};
  assign sym_idx   = {temp_q[7], temp_q} - {2'b00, display_offset_q};

  // rotary step with saturation at both ends
  always_comb begin
    level_new = level_cur;
    if (step_up_q) begin
      if (level_cur != 8'hFF) begin
        level_new = level_cur + 8'd1;
      end
    end else if (level_cur != 8'h00) begin
      level_new = level_cur - 8'd1;
    end
  end

  // sample symbol, index clamped to minus .. plus
  always_comb begin
    if ($signed(sym_idx) < $signed(9'sd0)) begin
      sym = SYM_MINUS;
    end else if ($signed(sym_idx) > $signed(9'sd10)) begin
      sym = SYM_PLUS;
    end else begin
      sym = sym_idx[3:0] + 4'd1;
    end
  end

  // event handling
  always_comb begin
    menu_d  = menu_q;
    idle_d  = idle_q;
    low_d   = low_q;
    high_d  = high_q;
    relay_d = relay_q;
    seg_d   = seg_q;
    case (cmd_q)
      CMD_BUTTON: begin
        idle_d = 16'd0;
        case (menu_q)
          MENU_LOW: begin
            menu_d = MENU_HIGH;
            seg_d  = seg_pattern(SYM_PLUS);
          end
          MENU_HIGH: begin
            menu_d = MENU_NORMAL;
            seg_d  = seg_q | NORMAL_LIGHTS;
          end
          default: begin
            menu_d = MENU_LOW;
            seg_d  = seg_pattern(SYM_MINUS);
          end
        endcase
      end
      CMD_TICK: begin
        if (setup) begin
          if (idle_inc > idle_timeout_q) begin
            menu_d = MENU_NORMAL;
            idle_d = 16'd0;
          end else begin
            idle_d = idle_inc;
          end
        end
      end
      CMD_ROTARY: begin
        if (setup) begin
          idle_d = 16'd0;
          if (menu_q == MENU_HIGH) begin
            high_d = level_new;
          end else begin
            low_d = level_new;
          end
        end
      end
      default: begin
        if (!setup) begin
          if ($signed(temp_ext) > $signed({2'b00, high_q})) begin
            relay_d = 1'b0;
          end else if ($signed(temp_ext) < $signed({2'b00, low_q})) begin
            relay_d = 1'b1;
          end
          seg_d = seg_pattern(sym);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      menu_q  <= MENU_LOW;
      idle_q  <= 16'd0;
      low_q   <= LowLevelReset;
      high_q  <= HighLevelReset;
      relay_q <= 1'b0;
      seg_q   <= 7'd0;
    end else if (proc) begin
      menu_q  <= menu_d;
      idle_q  <= idle_d;
      low_q   <= low_d;
      high_q  <= high_d;
      relay_q <= relay_d;
      seg_q   <= seg_d;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, high_q, low_q, seg_q, menu_q, relay_q};

  // idle counter only runs in a setup mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    menu_q == MENU_NORMAL |-> idle_q == 16'd0)
    else $error("idle counter nonzero in normal mode");

  // relay moves only on a processed sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(relay_q) |-> $past(proc && cmd_q == CMD_SAMPLE))
    else $error("relay changed without a sample");

  // thresholds move only on a rotary step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$stable(low_q) || !$stable(high_q)) |-> $past(proc && cmd_q == CMD_ROTARY))
    else $error("threshold changed without a rotary step");

  // a stalled input request is kept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("input request dropped");

endmodule
